>>> rtl/bit_run_to_pulse_duration_defines.svh
// Assertion macros for the pulse duration encoder.
`ifndef BIT_RUN_TO_PULSE_DURATION_DEFINES_SVH
`define BIT_RUN_TO_PULSE_DURATION_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled in reset.
`define BRPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brpd assertion failed");
// Next-cycle implication, clocked on clk and disabled in reset.
`define BRPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brpd assertion failed");
`else
`define BRPD_ASSERT_NOW(label, ante, cons)
`define BRPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/brpd_pkg.sv
package brpd_pkg;

    // One message bit and its end-of-message flag.
    typedef struct packed {
        logic bit_value;
        logic final_bit;
    } in_word_t;

    // One level and duration segment.
    typedef struct packed {
        logic        level;
        logic [31:0] duration_us;
        logic        end_marker;
        logic        last_result;
    } out_word_t;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_PULSE_UNIT = 2'd0,
        REG_START_GAP  = 2'd1,
        REG_END_GAP    = 2'd2
    } reg_idx_t;

    localparam int unsigned PADDR_W      = 4;
    localparam int unsigned UNIT_W       = 16;
    localparam int unsigned GAP_W        = 20;
    localparam int unsigned DUR_W        = 32;
    localparam int unsigned MAX_RESULTS  = 4;
    localparam int unsigned NEW_CNT_W    = 3;

    localparam logic [UNIT_W-1:0] PULSE_UNIT_RESET = 16'd1;
    localparam logic [GAP_W-1:0]  GAP_RESET        = 20'd10000;
    localparam logic [DUR_W-1:0]  DUR_MAX          = 32'hFFFF_FFFF;

endpackage

>>> rtl/bit_run_to_pulse_duration.sv
// Bit run to pulse duration encoder.
//
// Input channel (bit_valid / bit_stall / bit_data): one message bit a word,
// with final_bit set on the last bit of a message. Output channel
// (seg_valid / seg_stall / seg_data): level and duration segments, the
// start gap ahead of a message, an end gap and an end marker after it.
// A word is taken at a rising edge with valid high and stall low.
//
// A bit's segments are registered into the result queue behind held words,
// then leave one per cycle while seg_stall is low. Throughput: one bit per
// cycle while bit_stall is low; a bit causes zero to four segments, several
// only at message edges. Queue depth is QUEUE_DEPTH words; bit_stall rises
// while more than QUEUE_DEPTH-4 words are queued, so a stalled receiver
// backs up the queue and then the sender, and nothing is dropped.
//
// Registers over APB at byte addresses 0 (pulse_unit_us), 4 (start_gap_us)
// and 8 (end_gap_us); write only while the block is idle.
// Reset: registers return to 1, 10000 and 10000, the queue empties and the
// block awaits the first bit of a message.
`include "bit_run_to_pulse_duration_defines.svh"

module bit_run_to_pulse_duration #(
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // bit channel
    input  logic                                 bit_valid,
    output logic                                 bit_stall,
    input  brpd_pkg::in_word_t                   bit_data,
    // segment channel
    output logic                                 seg_valid,
    input  logic                                 seg_stall,
    output brpd_pkg::out_word_t                  seg_data,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [brpd_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] STALL_ABOVE =
        CNT_W'(QUEUE_DEPTH - brpd_pkg::MAX_RESULTS);

    // Configuration registers
    logic [brpd_pkg::UNIT_W-1:0] pulse_unit_reg;
    logic [brpd_pkg::GAP_W-1:0]  start_gap_reg;
    logic [brpd_pkg::GAP_W-1:0]  end_gap_reg;
    logic                        cfg_write;
    brpd_pkg::reg_idx_t          cfg_idx;

    // Run state
    logic                        in_message_reg, in_message_next;
    logic                        run_level_reg, run_level_next;
    logic [brpd_pkg::DUR_W-1:0]  run_dur_reg, run_dur_next;

    // Result queue: slot 0 is the word on the output
    brpd_pkg::out_word_t         slot_reg  [QUEUE_DEPTH];
    brpd_pkg::out_word_t         slot_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CNT_W-1:0]            base;

    // Handshakes
    logic                        accept;
    logic                        pop;

    // Per-bit results
    logic [brpd_pkg::DUR_W:0]    sum;
    logic [brpd_pkg::DUR_W-1:0]  dur_ext;
    logic                        lvl_upd;
    logic [brpd_pkg::DUR_W-1:0]  dur_upd;
    brpd_pkg::out_word_t         cand   [brpd_pkg::MAX_RESULTS];
    logic [brpd_pkg::MAX_RESULTS-1:0] cand_en;
    brpd_pkg::out_word_t         new_w  [brpd_pkg::MAX_RESULTS];
    logic [brpd_pkg::NEW_CNT_W-1:0] n_new;

    // ------------------------------------------------------------------
    // Configuration port: always ready, index from the word address.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = brpd_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_unit_reg <= brpd_pkg::PULSE_UNIT_RESET;
            start_gap_reg  <= brpd_pkg::GAP_RESET;
            end_gap_reg    <= brpd_pkg::GAP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                brpd_pkg::REG_PULSE_UNIT: pulse_unit_reg <= pwdata[brpd_pkg::UNIT_W-1:0];
                brpd_pkg::REG_START_GAP:  start_gap_reg  <= pwdata[brpd_pkg::GAP_W-1:0];
                brpd_pkg::REG_END_GAP:    end_gap_reg    <= pwdata[brpd_pkg::GAP_W-1:0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            brpd_pkg::REG_PULSE_UNIT: prdata = 32'(pulse_unit_reg);
            brpd_pkg::REG_START_GAP:  prdata = 32'(start_gap_reg);
            brpd_pkg::REG_END_GAP:    prdata = 32'(end_gap_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes. The input stalls only on queue fill, so room for the
    // worst-case four words is always there when a bit is taken.
    // ------------------------------------------------------------------
    assign seg_valid = (cnt_reg != '0);
    assign seg_data  = slot_reg[0];
    assign pop       = seg_valid && !seg_stall;
    assign bit_stall = (cnt_reg > STALL_ABOVE);
    assign accept    = bit_valid && !bit_stall;
    assign base      = cnt_reg - CNT_W'(pop);

    // ------------------------------------------------------------------
    // Run tracking: extend the open run with a saturating add, or start a
    // new run on the first bit of a message or on a change of level.
    // ------------------------------------------------------------------
    assign dur_ext = 32'(pulse_unit_reg);
    assign sum     = {1'b0, run_dur_reg} + {1'b0, dur_ext};

    always_comb
    begin
        if (in_message_reg && (bit_data.bit_value == run_level_reg))
        begin
            lvl_upd = run_level_reg;
            dur_upd = sum[brpd_pkg::DUR_W] ? brpd_pkg::DUR_MAX
                                           : sum[brpd_pkg::DUR_W-1:0];
        end
        else
        begin
            lvl_upd = bit_data.bit_value;
            dur_upd = dur_ext;
        end

        if (bit_data.final_bit)
        begin
            in_message_next = 1'b0;
            run_level_next  = 1'b0;
            run_dur_next    = '0;
        end
        else
        begin
            in_message_next = 1'b1;
            run_level_next  = lvl_upd;
            run_dur_next    = dur_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
            run_level_reg  <= 1'b0;
            run_dur_reg    <= '0;
        end
        else if (accept)
        begin
            in_message_reg <= in_message_next;
            run_level_reg  <= run_level_next;
            run_dur_reg    <= run_dur_next;
        end
    end

    // ------------------------------------------------------------------
    // Candidate segments in emission order: start gap or closed run, the
    // final run, the end gap, the end marker. Pack the enabled ones.
    // ------------------------------------------------------------------
    always_comb
    begin
        cand[0] = '0;
        if (!in_message_reg)
        begin
            cand[0].duration_us = 32'(start_gap_reg);
            cand_en[0]          = (start_gap_reg != '0);
        end
        else
        begin
            cand[0].level       = run_level_reg;
            cand[0].duration_us = run_dur_reg;
            cand_en[0]          = (bit_data.bit_value != run_level_reg);
        end

        cand[1]             = '0;
        cand[1].level       = lvl_upd;
        cand[1].duration_us = dur_upd;
        cand_en[1]          = bit_data.final_bit;

        cand[2]             = '0;
        cand[2].duration_us = 32'(end_gap_reg);
        cand_en[2]          = bit_data.final_bit && (end_gap_reg != '0);

        cand[3]            = '0;
        cand[3].end_marker = 1'b1;
        cand_en[3]         = bit_data.final_bit;
    end

    always_comb
    begin
        n_new = '0;
        for (int k = 0; k < brpd_pkg::MAX_RESULTS; k++)
        begin
            new_w[k] = '0;
        end
        for (int k = 0; k < brpd_pkg::MAX_RESULTS; k++)
        begin
            if (cand_en[k])
            begin
                new_w[n_new[1:0]] = cand[k];
                n_new = n_new + 3'd1;
            end
        end
        // flag the last segment of this bit
        for (int k = 0; k < brpd_pkg::MAX_RESULTS; k++)
        begin
            new_w[k].last_result = (brpd_pkg::NEW_CNT_W'(k + 1) == n_new);
        end
    end

    // ------------------------------------------------------------------
    // Result queue: shift down on pop, append new segments behind the
    // words that stay.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [CNT_W-1:0] off;
        int unsigned      src;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            src = (i < QUEUE_DEPTH - 1) ? i + 1 : i;
            off = CNT_W'(i) - base;
            slot_next[i] = slot_reg[i];
            if (CNT_W'(i) < base)
            begin
                if (pop)
                begin
                    slot_next[i] = slot_reg[src];
                end
            end
            else if (accept && (off < CNT_W'(n_new)))
            begin
                slot_next[i] = new_w[off[1:0]];
            end
        end
        cnt_next = base + (accept ? CNT_W'(n_new) : '0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `BRPD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(QUEUE_DEPTH))
    `BRPD_ASSERT_NEXT(a_final_closes, accept && bit_data.final_bit, !in_message_reg && (cnt_reg >= $past(base) + CNT_W'(2)))
    `BRPD_ASSERT_NOW(a_marker_last, seg_valid && seg_data.end_marker, seg_data.last_result && !seg_data.level && (seg_data.duration_us == '0))

endmodule

>>> tb/tb_bit_run_to_pulse_duration.sv
module tb_bit_run_to_pulse_duration;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 3 decodes to no register; writes there must be dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 20;
    localparam int WORDS_PER_PH  = 160;

    typedef enum logic {
        ROW_BIT,
        ROW_REG
    } row_kind_t;

    // One line of the directed table: either a bit word or a register write.
    // n_fixed < 0 means the segments come from the encoder model.
    typedef struct packed {
        row_kind_t                                       kind;
        brpd_pkg::in_word_t                              word;
        logic [1:0]                                      idx;
        logic [31:0]                                     value;
        int                                              n_fixed;
        brpd_pkg::out_word_t [brpd_pkg::MAX_RESULTS-1:0] fixed;
    } row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          bit_valid;
    logic                          bit_stall;
    brpd_pkg::in_word_t            bit_data;
    logic                          seg_valid;
    logic                          seg_stall;
    brpd_pkg::out_word_t           seg_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [brpd_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // Encoder model: register copies and open-run state.
    logic [brpd_pkg::UNIT_W-1:0] unit_q;
    logic [brpd_pkg::GAP_W-1:0]  start_gap_q;
    logic [brpd_pkg::GAP_W-1:0]  end_gap_q;
    logic                        msg_open;
    logic                        run_lvl;
    logic [brpd_pkg::DUR_W-1:0]  run_dur;

    // Segments produced by the latest bit, and every segment still owed.
    brpd_pkg::out_word_t   step_segs [brpd_pkg::MAX_RESULTS];
    int                    step_n;
    brpd_pkg::out_word_t   segs_owed [$];
    row_t                  stim_rows [$];

    int          err_cnt;
    int          cycle_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;

    bit_run_to_pulse_duration uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_valid (bit_valid),
        .bit_stall (bit_stall),
        .bit_data  (bit_data),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg_data  (seg_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------

    function automatic brpd_pkg::out_word_t mk_seg(input logic lvl,
                                                   input logic [brpd_pkg::DUR_W-1:0] dur,
                                                   input logic marker);
        brpd_pkg::out_word_t s;
        s.level       = lvl;
        s.duration_us = dur;
        s.end_marker  = marker;
        s.last_result = 1'b0;
        return s;
    endfunction

    function automatic void model_reset();
        unit_q      = brpd_pkg::PULSE_UNIT_RESET;
        start_gap_q = brpd_pkg::GAP_RESET;
        end_gap_q   = brpd_pkg::GAP_RESET;
        msg_open    = 1'b0;
        run_lvl     = 1'b0;
        run_dur     = '0;
    endfunction

    // Mask the written value to the register width; unknown indexes do nothing.
    function automatic void model_write(input logic [1:0] idx, input logic [31:0] value);
        case (idx)
            brpd_pkg::REG_PULSE_UNIT: unit_q      = value[brpd_pkg::UNIT_W-1:0];
            brpd_pkg::REG_START_GAP:  start_gap_q = value[brpd_pkg::GAP_W-1:0];
            brpd_pkg::REG_END_GAP:    end_gap_q   = value[brpd_pkg::GAP_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the run state by one message bit and fill step_segs with the
    // segments that bit releases.
    function automatic void encode_bit(input brpd_pkg::in_word_t w);
        logic [brpd_pkg::DUR_W:0] sum;
        step_n = 0;
        if (!msg_open)
        begin
            // First bit: start gap ahead of the message, unless disabled.
            if (start_gap_q != '0)
            begin
                step_segs[step_n] = mk_seg(1'b0, brpd_pkg::DUR_W'(start_gap_q), 1'b0);
                step_n++;
            end
            msg_open = 1'b1;
            run_lvl  = w.bit_value;
            run_dur  = brpd_pkg::DUR_W'(unit_q);
        end
        else if (w.bit_value == run_lvl)
        begin
            // Same level: extend the run, holding at the ceiling.
            sum     = {1'b0, run_dur} + (brpd_pkg::DUR_W + 1)'(unit_q);
            run_dur = sum[brpd_pkg::DUR_W] ? brpd_pkg::DUR_MAX : sum[brpd_pkg::DUR_W-1:0];
        end
        else
        begin
            // Level change: close the open run and start a new one.
            step_segs[step_n] = mk_seg(run_lvl, run_dur, 1'b0);
            step_n++;
            run_lvl = w.bit_value;
            run_dur = brpd_pkg::DUR_W'(unit_q);
        end

        if (w.final_bit)
        begin
            step_segs[step_n] = mk_seg(run_lvl, run_dur, 1'b0);
            step_n++;
            if (end_gap_q != '0)
            begin
                step_segs[step_n] = mk_seg(1'b0, brpd_pkg::DUR_W'(end_gap_q), 1'b0);
                step_n++;
            end
            step_segs[step_n] = mk_seg(1'b0, '0, 1'b1);
            step_n++;
            msg_open = 1'b0;
            run_lvl  = 1'b0;
            run_dur  = '0;
        end

        if (step_n > 0)
            step_segs[step_n-1].last_result = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    function automatic void add_bit(input logic bv, input logic fb);
        row_t r;
        r = '0;
        r.kind           = ROW_BIT;
        r.word.bit_value = bv;
        r.word.final_bit = fb;
        r.n_fixed        = -1;
        stim_rows.push_back(r);
    endfunction

    // Bit row whose segments are spelt out by hand.
    function automatic void add_fixed(input logic bv, input logic fb, input int n,
                                      input brpd_pkg::out_word_t s0,
                                      input brpd_pkg::out_word_t s1,
                                      input brpd_pkg::out_word_t s2,
                                      input brpd_pkg::out_word_t s3);
        row_t r;
        r = '0;
        r.kind           = ROW_BIT;
        r.word.bit_value = bv;
        r.word.final_bit = fb;
        r.n_fixed        = n;
        r.fixed[0]       = s0;
        r.fixed[1]       = s1;
        r.fixed[2]       = s2;
        r.fixed[3]       = s3;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [1:0] idx, input logic [31:0] value);
        row_t r;
        r = '0;
        r.kind    = ROW_REG;
        r.idx     = idx;
        r.value   = value;
        r.n_fixed = -1;
        stim_rows.push_back(r);
    endfunction

    // Gap values: off, one million, top of the 20-bit range, or raw 32-bit noise.
    function automatic logic [31:0] rand_gap();
        case ($urandom_range(4))
            0:       return 32'd0;
            1:       return 32'd1000000;
            2:       return 32'h000F_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Bit channel driver
    // ------------------------------------------------------------------

    // Called and returns at a falling edge. Hold the word until it is taken,
    // then owe either the hand-written segments or the model's.
    task automatic send_word(input brpd_pkg::in_word_t w, input int n_fixed,
                             input brpd_pkg::out_word_t [brpd_pkg::MAX_RESULTS-1:0] fixed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            bit_valid = 1'b0;
            bit_data  = brpd_pkg::in_word_t'($urandom_range(3));
            @(negedge clk);
        end
        bit_valid = 1'b1;
        bit_data  = w;
        do
            @(posedge clk);
        while (bit_stall);
        encode_bit(w);
        if (n_fixed >= 0)
        begin
            for (int k = 0; k < n_fixed; k++)
                segs_owed.push_back(fixed[k]);
        end
        else
        begin
            for (int k = 0; k < step_n; k++)
                segs_owed.push_back(step_segs[k]);
        end
        @(negedge clk);
    endtask

    // Drop valid and wait for every owed segment, then let the pipe settle.
    task automatic wait_drained();
        bit_valid = 1'b0;
        while (segs_owed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write, then read back known registers. Only ever called between
    // messages with nothing owed.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        wait_drained();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model_write(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx != REG_UNUSED)
        begin
            case (idx)
                brpd_pkg::REG_PULSE_UNIT: want = 32'(unit_q);
                brpd_pkg::REG_START_GAP:  want = 32'(start_gap_q);
                default:                  want = 32'(end_gap_q);
            endcase
            @(negedge clk);
            psel = 1'b1;
            @(negedge clk);
            penable = 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== want)
            begin
                $error("prdata: expected %0h, got %0h", want, prdata);
                err_cnt++;
            end
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    // Write all three registers with a fresh mix of extremes and noise;
    // now and then poke the unused index as well.
    task automatic pick_config();
        logic [31:0] unit_val;
        case ($urandom_range(5))
            0:       unit_val = 32'd0;
            1:       unit_val = 32'd1;
            2:       unit_val = 32'h0000_FFFF;
            default: unit_val = $urandom;
        endcase
        reg_write(brpd_pkg::REG_PULSE_UNIT, unit_val);
        reg_write(brpd_pkg::REG_START_GAP, rand_gap());
        reg_write(brpd_pkg::REG_END_GAP, rand_gap());
        if ($urandom_range(3) == 0)
            reg_write(REG_UNUSED, $urandom);
    endtask

    // One complete message of random bits; runs are favoured so that level
    // changes and same-level extensions both occur often.
    task automatic send_message(input int len);
        brpd_pkg::in_word_t w;
        w.bit_value = 1'($urandom_range(1));
        for (int i = 0; i < len; i++)
        begin
            if (i > 0 && $urandom_range(99) < 35)
                w.bit_value = ~w.bit_value;
            w.final_bit = (i == len - 1);
            send_word(w, -1, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Segment channel: random stall and checker
    // ------------------------------------------------------------------

    // Re-roll the receiver stall on every falling edge.
    initial
    begin
        seg_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            seg_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each taken segment with the oldest owed one, field by field.
    always @(posedge clk)
    begin : seg_check
        brpd_pkg::out_word_t want;
        if (rst_n && seg_valid && !seg_stall)
        begin
            if (segs_owed.size() == 0)
            begin
                $error("segment with none owed: level %0d duration_us %0d end_marker %0d",
                       seg_data.level, seg_data.duration_us, seg_data.end_marker);
                err_cnt++;
            end
            else
            begin
                want = segs_owed.pop_front();
                if (seg_data.level !== want.level)
                begin
                    $error("level: expected %0d, got %0d", want.level, seg_data.level);
                    err_cnt++;
                end
                if (seg_data.duration_us !== want.duration_us)
                begin
                    $error("duration_us: expected %0d, got %0d",
                           want.duration_us, seg_data.duration_us);
                    err_cnt++;
                end
                if (seg_data.end_marker !== want.end_marker)
                begin
                    $error("end_marker: expected %0d, got %0d",
                           want.end_marker, seg_data.end_marker);
                    err_cnt++;
                end
                if (seg_data.last_result !== want.last_result)
                begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, seg_data.last_result);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial
    begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $error("timeout after %0d cycles, %0d segments owed", cycle_cnt, segs_owed.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int sent;
        int len;
        int drain_wait;

        // Hold every input at a known value through reset.
        rst_n         = 1'b0;
        bit_valid     = 1'b0;
        bit_data      = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        err_cnt       = 0;
        send_idle_pct = 11;
        recv_idle_pct = 52;
        model_reset();

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table. Reset values first: unit 1, both gaps 10000.
        // A one-bit message straight out of reset gives the full four segments.
        add_fixed(1'b1, 1'b1, 4,
                  mk_seg(1'b0, 32'd10000, 1'b0), mk_seg(1'b1, 32'd1, 1'b0),
                  mk_seg(1'b0, 32'd10000, 1'b0), {1'b0, 32'd0, 1'b1, 1'b1});
        // Opening bit alone: only the start gap, flagged as last.
        add_fixed(1'b0, 1'b0, 1, {1'b0, 32'd10000, 1'b0, 1'b1}, '0, '0, '0);
        // Same level: the run grows quietly.
        add_fixed(1'b0, 1'b0, 0, '0, '0, '0, '0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b1);

        // Largest unit, no start gap, end gap at the top of its range.
        add_reg(brpd_pkg::REG_PULSE_UNIT, 32'h0000_FFFF);
        add_reg(brpd_pkg::REG_START_GAP, 32'd0);
        add_reg(brpd_pkg::REG_END_GAP, 32'h000F_FFFF);
        add_fixed(1'b1, 1'b0, 0, '0, '0, '0, '0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b1);

        // Zero unit: every run comes out with zero duration; end gap off.
        add_reg(brpd_pkg::REG_PULSE_UNIT, 32'd0);
        add_reg(brpd_pkg::REG_START_GAP, 32'h000F_FFFF);
        add_reg(brpd_pkg::REG_END_GAP, 32'd0);
        add_fixed(1'b0, 1'b0, 1, {1'b0, 32'h000F_FFFF, 1'b0, 1'b1}, '0, '0, '0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b1, 1'b1);
        add_bit(1'b0, 1'b1);

        // Over-wide writes are masked; the unused index is ignored.
        add_reg(brpd_pkg::REG_PULSE_UNIT, 32'hFFFF_0003);
        add_reg(brpd_pkg::REG_START_GAP, 32'hABC1_2345);
        add_reg(brpd_pkg::REG_END_GAP, 32'hFFF0_0010);
        add_reg(REG_UNUSED, 32'hDEAD_BEEF);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b0);
        add_bit(1'b1, 1'b0);
        add_bit(1'b0, 1'b1);

        // Unit of one, both gaps at one million.
        add_reg(brpd_pkg::REG_PULSE_UNIT, 32'd1);
        add_reg(brpd_pkg::REG_START_GAP, 32'd1000000);
        add_reg(brpd_pkg::REG_END_GAP, 32'd1000000);
        add_bit(1'b0, 1'b0);
        add_bit(1'b1, 1'b1);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_REG)
                reg_write(stim_rows[i].idx, stim_rows[i].value);
            else
                send_word(stim_rows[i].word, stim_rows[i].n_fixed, stim_rows[i].fixed);
        end

        // Random part, three idling regimes: sender light and receiver heavy,
        // then swapped, then none at all.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 52 : 0;
            recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 11 : 0;
            pick_config();

            sent = 0;
            while (sent < WORDS_PER_PH)
            begin
                // Registers change only between messages.
                if ($urandom_range(9) == 0)
                    pick_config();
                // Now and then hold off until the block has emptied.
                if ($urandom_range(15) == 0)
                    wait_drained();
                if ($urandom_range(9) == 0)
                    len = 1;
                else if ($urandom_range(7) == 0)
                    len = $urandom_range(20, 48);
                else
                    len = $urandom_range(2, 12);
                send_message(len);
                sent += len;
            end
        end

        // Let the last segments out, bounded, then a short tail.
        bit_valid  = 1'b0;
        drain_wait = 0;
        while (segs_owed.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_wait++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (segs_owed.size() != 0)
        begin
            $error("%0d segments never arrived", segs_owed.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
